FILE: sv/lzpc_pkg.sv
`timescale 1ns / 1ps

package lzpc_pkg;

   localparam int MAX_PHRASES = 4096;
   localparam int TABLE_SLOTS = 8192;
   localparam int SYMBOL_BITS = 8;
   localparam int LANES       = 4;

   // slot tag: 0 marks an empty slot, live tags run 1 .. EPOCH_MAX
   localparam int EPOCH_BITS = 4;

   localparam int SYMBOL_W = 8;
   localparam int COUNT_W  = 13;

   localparam logic [31:0] HASH_MULT    = 32'd2654435761;
   localparam int          HASH_SHIFT   = 15;
   localparam int          PARENT_SHIFT = 8;

   typedef struct packed {
      logic valid;
      logic resolved;
      logic found;
   } probe_type;

   typedef struct packed {
      logic we;
      logic sweep;
   } wr_ctl_type;

endpackage

FILE: sv/lzpc_ram.sv
`timescale 1ns / 1ps

module lzpc_ram #(
   parameter int  WIDTH     = 8,
   parameter int  DEPTH     = 32,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/lzpc_cell.sv
`timescale 1ns / 1ps

module lzpc_cell #(
   parameter int  LANE        = 0,
   parameter int  LANES       = lzpc_pkg::LANES,
   parameter int  WORDS       = lzpc_pkg::TABLE_SLOTS / lzpc_pkg::LANES,
   parameter int  NODE_BITS   = $clog2(lzpc_pkg::MAX_PHRASES + 1),
   parameter int  SYMBOL_BITS = lzpc_pkg::SYMBOL_BITS,
   localparam int LANE_BITS   = $clog2(LANES),
   localparam int WORD_BITS   = $clog2(WORDS),
   localparam int ENTRY_W     = lzpc_pkg::EPOCH_BITS + 2 * NODE_BITS + SYMBOL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lzpc_pkg::EPOCH_BITS-1:0] epoch,
   input  lzpc_pkg::probe_type             flags_i,
   input  logic [WORD_BITS-1:0]            word_i,
   input  logic [LANE_BITS-1:0]            first_i,
   input  logic [NODE_BITS-1:0]            parent_i,
   input  logic [SYMBOL_BITS-1:0]          sym_i,
   input  logic [LANE_BITS-1:0]            lane_i,
   input  logic [NODE_BITS-1:0]            child_i,
   output lzpc_pkg::probe_type             flags_o,
   output logic [WORD_BITS-1:0]            word_o,
   output logic [LANE_BITS-1:0]            first_o,
   output logic [NODE_BITS-1:0]            parent_o,
   output logic [SYMBOL_BITS-1:0]          sym_o,
   output logic [LANE_BITS-1:0]            lane_o,
   output logic [NODE_BITS-1:0]            child_o,
   input  lzpc_pkg::wr_ctl_type            wr_ctl,
   input  logic [LANE_BITS-1:0]            wr_lane,
   input  logic [WORD_BITS-1:0]            wr_addr,
   input  logic [ENTRY_W-1:0]              wr_data
);

   localparam logic [LANE_BITS-1:0] LANE_ID = LANE_BITS'(LANE);

   lzpc_pkg::probe_type    a_flags_ff;
   logic [WORD_BITS-1:0]   a_word_ff;
   logic [LANE_BITS-1:0]   a_first_ff;
   logic [NODE_BITS-1:0]   a_parent_ff;
   logic [SYMBOL_BITS-1:0] a_sym_ff;
   logic [LANE_BITS-1:0]   a_lane_ff;
   logic [NODE_BITS-1:0]   a_child_ff;

   lzpc_pkg::probe_type    flags_ff, flags_in;
   logic [WORD_BITS-1:0]   word_ff;
   logic [LANE_BITS-1:0]   first_ff;
   logic [NODE_BITS-1:0]   parent_ff;
   logic [SYMBOL_BITS-1:0] sym_ff;
   logic [LANE_BITS-1:0]   lane_ff, lane_in;
   logic [NODE_BITS-1:0]   child_ff, child_in;

   logic                            ram_we;
   logic [ENTRY_W-1:0]              rd;
   logic [lzpc_pkg::EPOCH_BITS-1:0] rd_tag;
   logic [NODE_BITS-1:0]            rd_parent;
   logic [SYMBOL_BITS-1:0]          rd_sym;
   logic [NODE_BITS-1:0]            rd_child;

   assign ram_we = wr_ctl.we && (wr_ctl.sweep || wr_lane == LANE_ID);

   lzpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WORDS)
   ) u_bank (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (flags_i.valid),
      .raddr (word_i),
      .rdata (rd)
   );

   assign rd_tag    = rd[ENTRY_W-1 -: lzpc_pkg::EPOCH_BITS];
   assign rd_parent = rd[2 * NODE_BITS + SYMBOL_BITS - 1 -: NODE_BITS];
   assign rd_sym    = rd[NODE_BITS + SYMBOL_BITS - 1 -: SYMBOL_BITS];
   assign rd_child  = rd[NODE_BITS-1:0];

   // first hit in slot order wins; lanes below the home slot are skipped
   always_comb begin
      flags_in = a_flags_ff;
      lane_in  = a_lane_ff;
      child_in = a_child_ff;
      if (a_flags_ff.valid && !a_flags_ff.resolved && LANE_ID >= a_first_ff) begin
         if (rd_tag != epoch) begin
            flags_in.resolved = 1'b1;
            flags_in.found    = 1'b0;
            lane_in           = LANE_ID;
         end else if (rd_parent == a_parent_ff && rd_sym == a_sym_ff) begin
            flags_in.resolved = 1'b1;
            flags_in.found    = 1'b1;
            lane_in           = LANE_ID;
            child_in          = rd_child;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
         flags_ff   <= '0;
      end else begin
         a_flags_ff <= flags_i;
         flags_ff   <= flags_in;
      end
      a_word_ff   <= word_i;
      a_first_ff  <= first_i;
      a_parent_ff <= parent_i;
      a_sym_ff    <= sym_i;
      a_lane_ff   <= lane_i;
      a_child_ff  <= child_i;
      word_ff     <= a_word_ff;
      first_ff    <= a_first_ff;
      parent_ff   <= a_parent_ff;
      sym_ff      <= a_sym_ff;
      lane_ff     <= lane_in;
      child_ff    <= child_in;
   end

   assign flags_o  = flags_ff;
   assign word_o   = word_ff;
   assign first_o  = first_ff;
   assign parent_o = parent_ff;
   assign sym_o    = sym_ff;
   assign lane_o   = lane_ff;
   assign child_o  = child_ff;

endmodule

FILE: sv/lzpc_ctrl.sv
`timescale 1ns / 1ps

module lzpc_ctrl #(
   parameter int  MAX_PHRASES = lzpc_pkg::MAX_PHRASES,
   parameter int  TABLE_SLOTS = lzpc_pkg::TABLE_SLOTS,
   parameter int  SYMBOL_BITS = lzpc_pkg::SYMBOL_BITS,
   parameter int  LANES       = lzpc_pkg::LANES,
   localparam int NODE_BITS   = $clog2(MAX_PHRASES + 1),
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS),
   localparam int LANE_BITS   = $clog2(LANES),
   localparam int WORD_BITS   = SLOT_BITS - LANE_BITS,
   localparam int ENTRY_W     = lzpc_pkg::EPOCH_BITS + 2 * NODE_BITS + SYMBOL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lzpc_pkg::SYMBOL_W-1:0]   req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lzpc_pkg::COUNT_W-1:0]    rsp_count,
   output logic                            rsp_closed,
   output logic                            rsp_full,
   output logic [lzpc_pkg::EPOCH_BITS-1:0] epoch,
   output lzpc_pkg::probe_type             launch_flags,
   output logic [WORD_BITS-1:0]            launch_word,
   output logic [LANE_BITS-1:0]            launch_first,
   output logic [NODE_BITS-1:0]            launch_parent,
   output logic [SYMBOL_BITS-1:0]          launch_sym,
   input  lzpc_pkg::probe_type             ret_flags,
   input  logic [LANE_BITS-1:0]            ret_lane,
   input  logic [NODE_BITS-1:0]            ret_child,
   output lzpc_pkg::wr_ctl_type            wr_ctl,
   output logic [LANE_BITS-1:0]            wr_lane,
   output logic [WORD_BITS-1:0]            wr_addr,
   output logic [ENTRY_W-1:0]              wr_data
);

   localparam int WORDS      = TABLE_SLOTS / LANES;
   localparam int GROUPS     = WORDS + 1;
   localparam int GROUP_BITS = $clog2(GROUPS + 1);

   localparam logic [WORD_BITS-1:0]  LAST_WORD  = WORD_BITS'(WORDS - 1);
   localparam logic [GROUP_BITS-1:0] GROUP_INIT = GROUP_BITS'(GROUPS);
   localparam logic [NODE_BITS-1:0]  MAX_COUNT  = NODE_BITS'(MAX_PHRASES);
   localparam logic [lzpc_pkg::SYMBOL_W-1:0] SYM_MASK =
      lzpc_pkg::SYMBOL_W'((1 << SYMBOL_BITS) - 1);
   localparam logic [lzpc_pkg::EPOCH_BITS-1:0] EPOCH_FIRST = lzpc_pkg::EPOCH_BITS'(1);
   localparam logic [lzpc_pkg::EPOCH_BITS-1:0] EPOCH_MAX =
      lzpc_pkg::EPOCH_BITS'((1 << lzpc_pkg::EPOCH_BITS) - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_MIX    = 3'd3;
   localparam logic [2:0] S_LAUNCH = 3'd4;
   localparam logic [2:0] S_WAIT   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic [lzpc_pkg::EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic                            item_ff, item_in;
   logic [WORD_BITS-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [lzpc_pkg::SYMBOL_W-1:0]   sym_ff, sym_in;
   logic [NODE_BITS-1:0]            node_ff, node_in;
   logic [NODE_BITS-1:0]            count_ff, count_in;
   logic [31:0]                     prod_ff, prod_in;
   logic [WORD_BITS-1:0]            word_ff, word_in;
   logic [LANE_BITS-1:0]            first_ff, first_in;
   logic [GROUP_BITS-1:0]           groups_ff, groups_in;
   logic                            closed_ff, closed_in;
   logic                            dropped_ff, dropped_in;
   lzpc_pkg::wr_ctl_type            wr_ctl_ff, wr_ctl_in;
   logic [LANE_BITS-1:0]            wr_lane_ff, wr_lane_in;
   logic [WORD_BITS-1:0]            wr_addr_ff, wr_addr_in;
   logic [ENTRY_W-1:0]              wr_data_ff, wr_data_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [lzpc_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                            rsp_closed_ff, rsp_closed_in;
   logic                            rsp_full_ff, rsp_full_in;

   logic [31:0]          key;
   logic [31:0]          mix;
   logic [SLOT_BITS-1:0] slot;
   logic [31:0]          count_wide;
   logic [NODE_BITS-1:0] count_inc;

   assign key = (32'(node_ff) << lzpc_pkg::PARENT_SHIFT) ^ 32'(sym_ff);
   assign mix = prod_ff ^ (prod_ff >> lzpc_pkg::HASH_SHIFT);
   assign slot       = mix[SLOT_BITS-1:0];
   assign count_wide = 32'(count_ff);
   assign count_inc  = NODE_BITS'(count_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      item_in       = item_ff;
      sweep_addr_in = sweep_addr_ff;
      sym_in        = sym_ff;
      node_in       = node_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      groups_in     = groups_ff;
      closed_in     = closed_ff;
      dropped_in    = dropped_ff;
      wr_ctl_in     = '0;
      wr_lane_in    = wr_lane_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_full_in   = rsp_full_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_ctl_in.we    = 1'b1;
            wr_ctl_in.sweep = 1'b1;
            wr_addr_in      = sweep_addr_ff;
            wr_data_in      = '0;
            sweep_addr_in   = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == LAST_WORD) begin
               epoch_in = EPOCH_FIRST;
               item_in  = 1'b0;
               state_in = item_ff ? S_HASH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               sym_in   = req_tdata & SYM_MASK;
               state_in = S_HASH;
               if (req_tuser) begin
                  node_in  = '0;
                  count_in = '0;
                  if (epoch_ff == EPOCH_MAX) begin
                     item_in       = 1'b1;
                     sweep_addr_in = '0;
                     state_in      = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         S_HASH: begin
            prod_in  = key * lzpc_pkg::HASH_MULT;
            state_in = S_MIX;
         end
         S_MIX: begin
            word_in   = slot[SLOT_BITS-1:LANE_BITS];
            first_in  = slot[LANE_BITS-1:0];
            groups_in = GROUP_INIT;
            state_in  = S_LAUNCH;
         end
         S_LAUNCH: begin
            groups_in = groups_ff - 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (ret_flags.valid) begin
               if (ret_flags.resolved) begin
                  closed_in  = 1'b0;
                  dropped_in = 1'b0;
                  state_in   = S_DONE;
                  if (ret_flags.found) begin
                     node_in = ret_child;
                  end else begin
                     node_in = '0;
                     if (count_ff >= MAX_COUNT) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_ctl_in.we = 1'b1;
                        wr_lane_in   = ret_lane;
                        wr_addr_in   = word_ff;
                        wr_data_in   = {epoch_ff, node_ff, sym_ff[SYMBOL_BITS-1:0], count_inc};
                        count_in     = count_inc;
                        closed_in    = 1'b1;
                     end
                  end
               end else if (groups_ff == '0) begin
                  // every slot occupied and no match
                  closed_in  = 1'b0;
                  dropped_in = 1'b1;
                  node_in    = '0;
                  state_in   = S_DONE;
               end else begin
                  word_in  = word_ff + 1'b1;
                  first_in = '0;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_count_in  = count_wide[lzpc_pkg::COUNT_W-1:0];
               rsp_closed_in = closed_ff;
               rsp_full_in   = dropped_ff || count_ff >= MAX_COUNT;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         epoch_ff      <= EPOCH_FIRST;
         item_ff       <= 1'b0;
         sweep_addr_ff <= '0;
         node_ff       <= '0;
         count_ff      <= '0;
         wr_ctl_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         item_ff       <= item_in;
         sweep_addr_ff <= sweep_addr_in;
         node_ff       <= node_in;
         count_ff      <= count_in;
         wr_ctl_ff     <= wr_ctl_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      sym_ff        <= sym_in;
      prod_ff       <= prod_in;
      word_ff       <= word_in;
      first_ff      <= first_in;
      groups_ff     <= groups_in;
      closed_ff     <= closed_in;
      dropped_ff    <= dropped_in;
      wr_lane_ff    <= wr_lane_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_closed = rsp_closed_ff;
   assign rsp_full   = rsp_full_ff;
   assign epoch      = epoch_ff;

   always_comb begin
      launch_flags          = '0;
      launch_flags.valid    = state_ff == S_LAUNCH;
   end
   assign launch_word   = word_ff;
   assign launch_first  = first_ff;
   assign launch_parent = node_ff;
   assign launch_sym    = sym_ff[SYMBOL_BITS-1:0];

   assign wr_ctl  = wr_ctl_ff;
   assign wr_lane = wr_lane_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;

endmodule

FILE: sv/lz78_phrase_complexity_counter.sv
`timescale 1ns / 1ps

// LZ78 phrase counter: one symbol per transfer in, one result per transfer out
// carrying the running phrase count and the closed/full flags. The phrase table
// is a linear-probing hash table split over LANES cells, each owning one RAM
// bank; a probe walks LANES consecutive slots down the cell row, each cell
// registering its bank read and then its result. A lookup that a probe group
// does not settle goes on to the next group of LANES slots. After reset, and
// on every fifteenth new_string, the table is swept clean, all banks written
// together, during which no symbol is taken. TABLE_SLOTS and LANES must be
// powers of two, LANES >= 2.
module lz78_phrase_complexity_counter #(
   parameter int MAX_PHRASES = lzpc_pkg::MAX_PHRASES,
   parameter int TABLE_SLOTS = lzpc_pkg::TABLE_SLOTS,
   parameter int SYMBOL_BITS = lzpc_pkg::SYMBOL_BITS,
   parameter int LANES       = lzpc_pkg::LANES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] new_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [12:0] running_count, [15:13] zero
   output logic [1:0]  rsp_tuser    // [0] phrase_closed, [1] table_full
);

   localparam int NODE_BITS = $clog2(MAX_PHRASES + 1);
   localparam int LANE_BITS = $clog2(LANES);
   localparam int WORDS     = TABLE_SLOTS / LANES;
   localparam int WORD_BITS = $clog2(WORDS);
   localparam int ENTRY_W   = lzpc_pkg::EPOCH_BITS + 2 * NODE_BITS + SYMBOL_BITS;

   logic [lzpc_pkg::COUNT_W-1:0]    rsp_count;
   logic                            rsp_closed;
   logic                            rsp_full;
   logic [lzpc_pkg::EPOCH_BITS-1:0] epoch;

   lzpc_pkg::probe_type    chain_flags  [LANES+1];
   logic [WORD_BITS-1:0]   chain_word   [LANES+1];
   logic [LANE_BITS-1:0]   chain_first  [LANES+1];
   logic [NODE_BITS-1:0]   chain_parent [LANES+1];
   logic [SYMBOL_BITS-1:0] chain_sym    [LANES+1];
   logic [LANE_BITS-1:0]   chain_lane   [LANES+1];
   logic [NODE_BITS-1:0]   chain_child  [LANES+1];

   lzpc_pkg::wr_ctl_type   wr_ctl;
   logic [LANE_BITS-1:0]   wr_lane;
   logic [WORD_BITS-1:0]   wr_addr;
   logic [ENTRY_W-1:0]     wr_data;

   lzpc_ctrl #(
      .MAX_PHRASES (MAX_PHRASES),
      .TABLE_SLOTS (TABLE_SLOTS),
      .SYMBOL_BITS (SYMBOL_BITS),
      .LANES       (LANES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_count     (rsp_count),
      .rsp_closed    (rsp_closed),
      .rsp_full      (rsp_full),
      .epoch         (epoch),
      .launch_flags  (chain_flags[0]),
      .launch_word   (chain_word[0]),
      .launch_first  (chain_first[0]),
      .launch_parent (chain_parent[0]),
      .launch_sym    (chain_sym[0]),
      .ret_flags     (chain_flags[LANES]),
      .ret_lane      (chain_lane[LANES]),
      .ret_child     (chain_child[LANES]),
      .wr_ctl        (wr_ctl),
      .wr_lane       (wr_lane),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   assign chain_lane[0]  = '0;
   assign chain_child[0] = '0;

   for (genvar k = 0; k < LANES; k++) begin : g_cell
      lzpc_cell #(
         .LANE        (k),
         .LANES       (LANES),
         .WORDS       (WORDS),
         .NODE_BITS   (NODE_BITS),
         .SYMBOL_BITS (SYMBOL_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .epoch    (epoch),
         .flags_i  (chain_flags[k]),
         .word_i   (chain_word[k]),
         .first_i  (chain_first[k]),
         .parent_i (chain_parent[k]),
         .sym_i    (chain_sym[k]),
         .lane_i   (chain_lane[k]),
         .child_i  (chain_child[k]),
         .flags_o  (chain_flags[k+1]),
         .word_o   (chain_word[k+1]),
         .first_o  (chain_first[k+1]),
         .parent_o (chain_parent[k+1]),
         .sym_o    (chain_sym[k+1]),
         .lane_o   (chain_lane[k+1]),
         .child_o  (chain_child[k+1]),
         .wr_ctl   (wr_ctl),
         .wr_lane  (wr_lane),
         .wr_addr  (wr_addr),
         .wr_data  (wr_data)
      );
   end

   assign rsp_tdata = {3'b000, rsp_count};
   assign rsp_tuser = {rsp_full, rsp_closed};

endmodule
